/* hw/rtl/quadratic_least_squares_fit_macros.svh */
// Assertion macros for the checker file of the quadratic fit block.
`ifndef QUADRATIC_LEAST_SQUARES_FIT_MACROS_SVH
`define QUADRATIC_LEAST_SQUARES_FIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define QLSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic fit port rule violated");

// Next-cycle implication, sampled on clk and disabled during reset.
`define QLSF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic fit port rule violated");

`endif

/* hw/rtl/qlsf_pkg.sv */
// Types, register-file map and solve microprogram of the quadratic fit block.
`default_nettype none

package qlsf_pkg;

    localparam int COEFF_W = 64;
    localparam int NUM_REGS = 18;
    localparam int REG_AW = 5;
    localparam int NUM_OPS = 24;
    localparam int OP_IW = 5;

    localparam logic [REG_AW-1:0] R_M00 = 5'd0;
    localparam logic [REG_AW-1:0] R_M01 = 5'd1;
    localparam logic [REG_AW-1:0] R_M02 = 5'd2;
    localparam logic [REG_AW-1:0] R_M12 = 5'd3;
    localparam logic [REG_AW-1:0] R_M22 = 5'd4;
    localparam logic [REG_AW-1:0] R_B0 = 5'd5;
    localparam logic [REG_AW-1:0] R_B1 = 5'd6;
    localparam logic [REG_AW-1:0] R_B2 = 5'd7;
    localparam logic [REG_AW-1:0] R_C00 = 5'd8;
    localparam logic [REG_AW-1:0] R_C01 = 5'd9;
    localparam logic [REG_AW-1:0] R_C02 = 5'd10;
    localparam logic [REG_AW-1:0] R_C11 = 5'd11;
    localparam logic [REG_AW-1:0] R_C12 = 5'd12;
    localparam logic [REG_AW-1:0] R_C22 = 5'd13;
    localparam logic [REG_AW-1:0] R_DET = 5'd14;
    localparam logic [REG_AW-1:0] R_N0 = 5'd15;
    localparam logic [REG_AW-1:0] R_N1 = 5'd16;
    localparam logic [REG_AW-1:0] R_N2 = 5'd17;

    localparam logic [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
    localparam logic [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

    typedef struct packed {
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [REG_AW-1:0] dst;
        logic              sub;
        logic              first;
        logic              last;
    } op_t;

    function automatic op_t mk_op(input logic [REG_AW-1:0] ra, input logic [REG_AW-1:0] rb,
                                  input logic sub, input logic first, input logic last,
                                  input logic [REG_AW-1:0] dst);
        op_t o;
        o.ra = ra;
        o.rb = rb;
        o.dst = dst;
        o.sub = sub;
        o.first = first;
        o.last = last;
        return o;
    endfunction

    // Each entry adds or subtracts ra*rb in the accumulator; a group's last writes dst.
    function automatic op_t op_at(input logic [OP_IW-1:0] idx);
        op_t o;
        unique case (idx)
            5'd0:    o = mk_op(R_M02, R_M22, 1'b0, 1'b1, 1'b0, R_C00);
            5'd1:    o = mk_op(R_M12, R_M12, 1'b1, 1'b0, 1'b1, R_C00);
            5'd2:    o = mk_op(R_M02, R_M12, 1'b0, 1'b1, 1'b0, R_C01);
            5'd3:    o = mk_op(R_M01, R_M22, 1'b1, 1'b0, 1'b1, R_C01);
            5'd4:    o = mk_op(R_M01, R_M12, 1'b0, 1'b1, 1'b0, R_C02);
            5'd5:    o = mk_op(R_M02, R_M02, 1'b1, 1'b0, 1'b1, R_C02);
            5'd6:    o = mk_op(R_M00, R_M22, 1'b0, 1'b1, 1'b0, R_C11);
            5'd7:    o = mk_op(R_M02, R_M02, 1'b1, 1'b0, 1'b1, R_C11);
            5'd8:    o = mk_op(R_M01, R_M02, 1'b0, 1'b1, 1'b0, R_C12);
            5'd9:    o = mk_op(R_M00, R_M12, 1'b1, 1'b0, 1'b1, R_C12);
            5'd10:   o = mk_op(R_M00, R_M02, 1'b0, 1'b1, 1'b0, R_C22);
            5'd11:   o = mk_op(R_M01, R_M01, 1'b1, 1'b0, 1'b1, R_C22);
            5'd12:   o = mk_op(R_C00, R_M00, 1'b0, 1'b1, 1'b0, R_DET);
            5'd13:   o = mk_op(R_C01, R_M01, 1'b0, 1'b0, 1'b0, R_DET);
            5'd14:   o = mk_op(R_C02, R_M02, 1'b0, 1'b0, 1'b1, R_DET);
            5'd15:   o = mk_op(R_C00, R_B0, 1'b0, 1'b1, 1'b0, R_N0);
            5'd16:   o = mk_op(R_C01, R_B1, 1'b0, 1'b0, 1'b0, R_N0);
            5'd17:   o = mk_op(R_C02, R_B2, 1'b0, 1'b0, 1'b1, R_N0);
            5'd18:   o = mk_op(R_C01, R_B0, 1'b0, 1'b1, 1'b0, R_N1);
            5'd19:   o = mk_op(R_C11, R_B1, 1'b0, 1'b0, 1'b0, R_N1);
            5'd20:   o = mk_op(R_C12, R_B2, 1'b0, 1'b0, 1'b1, R_N1);
            5'd21:   o = mk_op(R_C02, R_B0, 1'b0, 1'b1, 1'b0, R_N2);
            5'd22:   o = mk_op(R_C12, R_B1, 1'b0, 1'b0, 1'b0, R_N2);
            5'd23:   o = mk_op(R_C22, R_B2, 1'b0, 1'b0, 1'b1, R_N2);
            default: o = mk_op(R_M00, R_M00, 1'b0, 1'b1, 1'b1, R_N2);
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/qlsf_ram.sv */
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module qlsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

/* hw/rtl/quadratic_least_squares_fit.sv */
// Top level of the quadratic least-squares fit: power-sum accumulation and exact solve.
//
// A sample point is taken as a transaction when start is high and busy is low. An
// ordinary point keeps busy high while one 24 by 24 bit multiplier builds
// x^2, x*y, x^3, x^4 and x^2*y in turn, so the next point is taken only once busy is low again.
// The point marked last then solves the normal equations exactly: 24 products go
// through one shift-and-add multiplier built on a single BW-bit adder, one bit per
// cycle, and the three quotients through a restoring divider on that same adder.
// BW is 3*clog2(MAX_POINTS+1) + 90. A zero determinant ends the solve early, with
// singular set, saturated clear and all three coefficients zero.
// The result is shown for exactly one cycle, marked by done; the receiver cannot
// stall it, and the coefficient ports hold their values until the next solve writes them.
`default_nettype none

module quadratic_least_squares_fit #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [11:0]                          x_value,
    input  wire logic [11:0]                          y_value,
    input  wire logic                                 last_point,
    output logic                                      done,
    output logic signed [qlsf_pkg::COEFF_W-1:0]       const_coeff,
    output logic signed [qlsf_pkg::COEFF_W-1:0]       linear_coeff,
    output logic signed [qlsf_pkg::COEFF_W-1:0]       quad_coeff,
    output logic                                      singular,
    output logic                                      saturated,
    output logic [4:0]                                points_used
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int S1W = 12 + CW;
    localparam int S2W = 24 + CW;
    localparam int S3W = 36 + CW;
    localparam int S4W = 48 + CW;
    localparam int BW = 3 * CW + 90;
    localparam int BCW = $clog2(BW);
    localparam int NB = BW - 1 + FRAC_BITS;
    localparam int DCW = $clog2(NB);
    localparam int QW = qlsf_pkg::COEFF_W;
    localparam int AW = qlsf_pkg::REG_AW;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_P5,
        S_P6,
        S_INIT,
        S_FETCH,
        S_LOAD,
        S_MUL,
        S_WB,
        S_DFETCH,
        S_DLOAD,
        S_DIV,
        S_RND,
        S_INC,
        S_FIX,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [11:0]     x_reg;
    logic [11:0]     y_reg;
    logic            last_reg;
    logic            acc_en_reg;
    logic [23:0]     x2_reg;
    logic [47:0]     p_reg;
    logic [CW-1:0]   count_reg;
    logic [S1W-1:0]  sum_x_reg;
    logic [S2W-1:0]  sum_x_sq_reg;
    logic [S3W-1:0]  sum_x_cube_reg;
    logic [S4W-1:0]  sum_x_quart_reg;
    logic [S1W-1:0]  sum_y_reg;
    logic [S2W-1:0]  sum_xy_reg;
    logic [S3W-1:0]  sum_x_sq_y_reg;

    logic [2:0]             init_idx_reg;
    logic [qlsf_pkg::OP_IW-1:0] op_idx_reg;
    logic [BW-1:0]          acc_reg;
    logic [BW-1:0]          a_sh_reg;
    logic [BW-1:0]          b_sh_reg;
    logic [BCW-1:0]         bit_cnt_reg;
    logic [DCW-1:0]         div_cnt_reg;
    logic [1:0]             k_reg;
    logic                   neg_reg;
    logic [BW-2:0]          num_sh_reg;
    logic [BW-2:0]          d_mag_reg;
    logic [BW-2:0]          rem_reg;
    logic [QW-1:0]          q_reg;
    logic                   q_ovf_reg;
    logic                   rnd_reg;
    logic [QW-1:0]          coeff_reg [3];
    logic                   singular_reg;
    logic                   sat_reg;
    logic                   done_reg;

    qlsf_pkg::op_t op;
    logic [23:0]   mul_a;
    logic [23:0]   mul_b;
    logic [BW-1:0] add_a;
    logic [BW-1:0] add_b;
    logic          add_sub;
    logic [BW:0]   sum_ext;
    logic          add_carry;
    logic [BW-1:0] add_res;
    logic [BW-1:0] div_shift;
    logic [BW-1:0] n_abs;
    logic [BW-1:0] d_abs;
    logic [QW:0]   inc_sum;
    logic [QW-1:0] fix_val;
    logic          fix_sat;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    logic [BW-1:0] ram_rdata_a;
    logic [BW-1:0] ram_rdata_b;
    logic [BW-1:0] init_val;

    assign op = qlsf_pkg::op_at(op_idx_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_P1:
            begin
                mul_a = {12'b0, x_reg};
                mul_b = {12'b0, x_reg};
            end
            S_P2:
            begin
                mul_a = {12'b0, x_reg};
                mul_b = {12'b0, y_reg};
            end
            S_P3:
            begin
                mul_a = x2_reg;
                mul_b = {12'b0, x_reg};
            end
            S_P4:
            begin
                mul_a = x2_reg;
                mul_b = x2_reg;
            end
            S_P5:
            begin
                mul_a = x2_reg;
                mul_b = {12'b0, y_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_shift = {rem_reg, num_sh_reg[BW-2]};

    always_comb
    begin
        add_a = acc_reg;
        add_b = a_sh_reg;
        add_sub = op.sub;
        case (state_reg)
            S_DIV:
            begin
                add_a = div_shift;
                add_b = {1'b0, d_mag_reg};
                add_sub = 1'b1;
            end
            S_RND:
            begin
                add_a = {rem_reg, 1'b0};
                add_b = {1'b0, d_mag_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_a = acc_reg;
                add_b = a_sh_reg;
                add_sub = op.sub;
            end
        endcase
    end

    assign sum_ext = {1'b0, add_a} + {1'b0, add_b ^ {BW{add_sub}}} + (BW+1)'(add_sub);
    assign add_carry = sum_ext[BW];
    assign add_res = sum_ext[BW-1:0];

    assign n_abs = ram_rdata_a[BW-1] ? (~ram_rdata_a + BW'(1)) : ram_rdata_a;
    assign d_abs = ram_rdata_b[BW-1] ? (~ram_rdata_b + BW'(1)) : ram_rdata_b;

    assign inc_sum = {1'b0, q_reg} + {{QW{1'b0}}, rnd_reg};

    always_comb
    begin
        if (!neg_reg)
        begin
            fix_sat = q_ovf_reg | q_reg[QW-1];
            fix_val = fix_sat ? qlsf_pkg::COEFF_MAX : q_reg;
        end
        else
        begin
            fix_sat = q_ovf_reg | (q_reg[QW-1] & (|q_reg[QW-2:0]));
            fix_val = fix_sat ? qlsf_pkg::COEFF_MIN : (~q_reg + QW'(1));
        end
    end

    always_comb
    begin
        case (init_idx_reg)
            3'd0:    init_val = BW'(count_reg);
            3'd1:    init_val = BW'(sum_x_reg);
            3'd2:    init_val = BW'(sum_x_sq_reg);
            3'd3:    init_val = BW'(sum_x_cube_reg);
            3'd4:    init_val = BW'(sum_x_quart_reg);
            3'd5:    init_val = BW'(sum_y_reg);
            3'd6:    init_val = BW'(sum_xy_reg);
            default: init_val = BW'(sum_x_sq_y_reg);
        endcase
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = op.dst;
        ram_wdata = acc_reg;
        ram_raddr_a = op.ra;
        ram_raddr_b = op.rb;
        case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                ram_waddr = AW'(init_idx_reg);
                ram_wdata = init_val;
            end
            S_WB:
            begin
                ram_we = 1'b1;
            end
            S_DFETCH:
            begin
                ram_raddr_a = qlsf_pkg::R_N0 + AW'(k_reg);
                ram_raddr_b = qlsf_pkg::R_DET;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    qlsf_ram #(
        .WIDTH(BW),
        .DEPTH(qlsf_pkg::NUM_REGS)
    ) u_regfile (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr_a(ram_raddr_a),
        .raddr_b(ram_raddr_b),
        .rdata_a(ram_rdata_a),
        .rdata_b(ram_rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg <= '0;
            y_reg <= '0;
            last_reg <= 1'b0;
            acc_en_reg <= 1'b0;
            x2_reg <= '0;
            p_reg <= '0;
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_x_sq_reg <= '0;
            sum_x_cube_reg <= '0;
            sum_x_quart_reg <= '0;
            sum_y_reg <= '0;
            sum_xy_reg <= '0;
            sum_x_sq_y_reg <= '0;
            init_idx_reg <= '0;
            op_idx_reg <= '0;
            acc_reg <= '0;
            a_sh_reg <= '0;
            b_sh_reg <= '0;
            bit_cnt_reg <= '0;
            k_reg <= '0;
            neg_reg <= 1'b0;
            num_sh_reg <= '0;
            d_mag_reg <= '0;
            rem_reg <= '0;
            q_reg <= '0;
            q_ovf_reg <= 1'b0;
            rnd_reg <= 1'b0;
            coeff_reg <= '{default: '0};
            singular_reg <= 1'b0;
            sat_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            p_reg <= mul_a * mul_b;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg <= x_value;
                        y_reg <= y_value;
                        last_reg <= last_point;
                        acc_en_reg <= (count_reg < CW'(MAX_POINTS));
                        state_reg <= S_P1;
                    end
                end
                S_P1:
                begin
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    x2_reg <= p_reg[23:0];
                    if (acc_en_reg)
                    begin
                        count_reg <= count_reg + CW'(1);
                        sum_x_reg <= sum_x_reg + S1W'(x_reg);
                        sum_y_reg <= sum_y_reg + S1W'(y_reg);
                        sum_x_sq_reg <= sum_x_sq_reg + S2W'(p_reg);
                    end
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    if (acc_en_reg)
                    begin
                        sum_xy_reg <= sum_xy_reg + S2W'(p_reg);
                    end
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    if (acc_en_reg)
                    begin
                        sum_x_cube_reg <= sum_x_cube_reg + S3W'(p_reg);
                    end
                    state_reg <= S_P5;
                end
                S_P5:
                begin
                    if (acc_en_reg)
                    begin
                        sum_x_quart_reg <= sum_x_quart_reg + S4W'(p_reg);
                    end
                    state_reg <= S_P6;
                end
                S_P6:
                begin
                    if (acc_en_reg)
                    begin
                        sum_x_sq_y_reg <= sum_x_sq_y_reg + S3W'(p_reg);
                    end
                    init_idx_reg <= '0;
                    state_reg <= last_reg ? S_INIT : S_IDLE;
                end
                S_INIT:
                begin
                    singular_reg <= 1'b0;
                    sat_reg <= 1'b0;
                    init_idx_reg <= init_idx_reg + 3'd1;
                    if (init_idx_reg == 3'd7)
                    begin
                        op_idx_reg <= '0;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    a_sh_reg <= ram_rdata_a;
                    b_sh_reg <= ram_rdata_b;
                    if (op.first)
                    begin
                        acc_reg <= '0;
                    end
                    bit_cnt_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (b_sh_reg[0])
                    begin
                        acc_reg <= add_res;
                    end
                    a_sh_reg <= {a_sh_reg[BW-2:0], 1'b0};
                    b_sh_reg <= {1'b0, b_sh_reg[BW-1:1]};
                    bit_cnt_reg <= bit_cnt_reg + BCW'(1);
                    if (bit_cnt_reg == BCW'(BW - 1))
                    begin
                        if (op.last)
                        begin
                            state_reg <= S_WB;
                        end
                        else
                        begin
                            op_idx_reg <= op_idx_reg + qlsf_pkg::OP_IW'(1);
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_WB:
                begin
                    if (op.dst == qlsf_pkg::R_DET && acc_reg == '0)
                    begin
                        coeff_reg <= '{default: '0};
                        singular_reg <= 1'b1;
                        sat_reg <= 1'b0;
                        done_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (op_idx_reg == qlsf_pkg::OP_IW'(qlsf_pkg::NUM_OPS - 1))
                    begin
                        k_reg <= '0;
                        state_reg <= S_DFETCH;
                    end
                    else
                    begin
                        op_idx_reg <= op_idx_reg + qlsf_pkg::OP_IW'(1);
                        state_reg <= S_FETCH;
                    end
                end
                S_DFETCH:
                begin
                    state_reg <= S_DLOAD;
                end
                S_DLOAD:
                begin
                    neg_reg <= ram_rdata_a[BW-1] ^ ram_rdata_b[BW-1];
                    num_sh_reg <= n_abs[BW-2:0];
                    d_mag_reg <= d_abs[BW-2:0];
                    rem_reg <= '0;
                    q_reg <= '0;
                    q_ovf_reg <= 1'b0;
                    bit_cnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= add_carry ? add_res[BW-2:0] : div_shift[BW-2:0];
                    q_reg <= {q_reg[QW-2:0], add_carry};
                    q_ovf_reg <= q_ovf_reg | q_reg[QW-1];
                    num_sh_reg <= {num_sh_reg[BW-3:0], 1'b0};
                    if (div_cnt_reg == DCW'(NB - 1))
                    begin
                        state_reg <= S_RND;
                    end
                end
                S_RND:
                begin
                    rnd_reg <= add_carry;
                    state_reg <= S_INC;
                end
                S_INC:
                begin
                    q_reg <= inc_sum[QW-1:0];
                    q_ovf_reg <= q_ovf_reg | inc_sum[QW];
                    state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    coeff_reg[k_reg] <= fix_val;
                    sat_reg <= sat_reg | fix_sat;
                    if (k_reg == 2'd2)
                    begin
                        done_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= S_DFETCH;
                    end
                end
                S_OUT:
                begin
                    count_reg <= '0;
                    sum_x_reg <= '0;
                    sum_x_sq_reg <= '0;
                    sum_x_cube_reg <= '0;
                    sum_x_quart_reg <= '0;
                    sum_y_reg <= '0;
                    sum_xy_reg <= '0;
                    sum_x_sq_y_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
        else
        begin
            div_cnt_reg <= '0;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign const_coeff = coeff_reg[0];
    assign linear_coeff = coeff_reg[1];
    assign quad_coeff = coeff_reg[2];
    assign singular = singular_reg;
    assign saturated = sat_reg;
    assign points_used = 5'(count_reg);

endmodule

`default_nettype wire

/* hw/rtl/qlsf_checker.sv */
// Port-level assertion checker for the quadratic fit block, with its bind statement.
`default_nettype none

`include "quadratic_least_squares_fit_macros.svh"

module qlsf_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic [qlsf_pkg::COEFF_W-1:0]      const_coeff,
    input wire logic [qlsf_pkg::COEFF_W-1:0]      linear_coeff,
    input wire logic [qlsf_pkg::COEFF_W-1:0]      quad_coeff,
    input wire logic                              singular,
    input wire logic                              saturated
);

    // Every accepted transaction keeps the block busy in the following cycle.
    `QLSF_ASSERT_NXT(a_accept_busy, start && !busy, busy)

    // A result only appears while the block is still busy with its last point.
    `QLSF_ASSERT_IMP(a_done_busy, done, busy)

    // A result is shown for a single cycle only.
    `QLSF_ASSERT_NXT(a_done_single, done, !done)

    // A singular system reports zero coefficients and no clamping.
    `QLSF_ASSERT_IMP(a_singular_zero, done && singular, const_coeff == '0 && linear_coeff == '0 && quad_coeff == '0 && !saturated)

endmodule

bind quadratic_least_squares_fit qlsf_checker u_qlsf_checker (.*);

`default_nettype wire

/* verif/quadratic_least_squares_fit_tb.sv */
// Quadratic least-squares fit testbench: directed and random point sets checked against an exact predictor.
`default_nettype none

module quadratic_least_squares_fit_tb;

    localparam int MAX_PTS = 16;
    localparam int FRAC = 32;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [63:0] c0;
        logic [63:0] c1;
        logic [63:0] c2;
        logic        sing;
        logic        sat;
        logic [4:0]  npts;
    } fit_t;

    class fit_scoreboard;
        logic [63:0] cnt, sx, sx2, sx3, sx4, sy, sxy, sx2y;
        fit_t pending_fits[$];
        int errors;

        function void clear_sums();
            cnt = 0; sx = 0; sx2 = 0; sx3 = 0; sx4 = 0; sy = 0; sxy = 0; sx2y = 0;
        endfunction

        function logic [63:0] to_fixed(wide_t num, wide_t den, inout logic sat);
            logic neg;
            logic [255:0] an, ad, q;
            logic [63:0] m;
            neg = num[255] != den[255];
            an = num[255] ? -num : num;
            ad = den[255] ? -den : den;
            q = ((an << (FRAC + 1)) + ad) / (ad << 1);
            m = q[63:0];
            if (q[255:64] != 0) begin
                sat = 1'b1;
                return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end
            if (!neg) begin
                if (m[63]) begin
                    sat = 1'b1;
                    return 64'h7FFF_FFFF_FFFF_FFFF;
                end
                return m;
            end
            if (m > 64'h8000_0000_0000_0000) begin
                sat = 1'b1;
                return 64'h8000_0000_0000_0000;
            end
            return -m;
        endfunction

        function void note_point(logic [11:0] x, logic [11:0] y, logic last);
            logic [63:0] x2;
            wide_t m00, m01, m02, m12, m22, b0, b1, b2;
            wide_t k00, k01, k02, k11, k12, k22, det;
            fit_t f;
            if (cnt < MAX_PTS) begin
                x2 = x * x;
                cnt += 1; sx += x; sx2 += x2; sx3 += x2 * x; sx4 += x2 * x2;
                sy += y; sxy += x * y; sx2y += x2 * y;
            end
            if (!last) return;
            m00 = cnt; m01 = sx; m02 = sx2; m12 = sx3; m22 = sx4;
            b0 = sy; b1 = sxy; b2 = sx2y;
            k00 = m02 * m22 - m12 * m12;
            k01 = m02 * m12 - m01 * m22;
            k02 = m01 * m12 - m02 * m02;
            k11 = m00 * m22 - m02 * m02;
            k12 = m01 * m02 - m00 * m12;
            k22 = m00 * m02 - m01 * m01;
            det = m00 * k00 + m01 * k01 + m02 * k02;
            f.npts = cnt[4:0];
            f.sat = 1'b0;
            if (det == 0) begin
                f.c0 = 0; f.c1 = 0; f.c2 = 0; f.sing = 1'b1;
            end else begin
                f.sing = 1'b0;
                f.c0 = to_fixed(k00 * b0 + k01 * b1 + k02 * b2, det, f.sat);
                f.c1 = to_fixed(k01 * b0 + k11 * b1 + k12 * b2, det, f.sat);
                f.c2 = to_fixed(k02 * b0 + k12 * b1 + k22 * b2, det, f.sat);
            end
            pending_fits.push_back(f);
            clear_sums();
        endfunction

        function void check_fit(fit_t got);
            fit_t e;
            if (pending_fits.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending_fits.pop_front();
            if (got.c0 !== e.c0) begin
                $error("const_coeff expected %h actual %h", e.c0, got.c0); errors++;
            end
            if (got.c1 !== e.c1) begin
                $error("linear_coeff expected %h actual %h", e.c1, got.c1); errors++;
            end
            if (got.c2 !== e.c2) begin
                $error("quad_coeff expected %h actual %h", e.c2, got.c2); errors++;
            end
            if (got.sing !== e.sing) begin
                $error("singular expected %b actual %b", e.sing, got.sing); errors++;
            end
            if (got.sat !== e.sat) begin
                $error("saturated expected %b actual %b", e.sat, got.sat); errors++;
            end
            if (got.npts !== e.npts) begin
                $error("points_used expected %0d actual %0d", e.npts, got.npts); errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [11:0] x_value = '0;
    logic [11:0] y_value = '0;
    logic last_point = 1'b0;
    logic busy, done, singular, saturated;
    logic signed [qlsf_pkg::COEFF_W-1:0] const_coeff, linear_coeff, quad_coeff;
    logic [4:0] points_used;

    fit_scoreboard sb;
    int sent;

    quadratic_least_squares_fit #(.MAX_POINTS(MAX_PTS), .FRAC_BITS(FRAC)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_value(x_value), .y_value(y_value), .last_point(last_point),
        .done(done), .const_coeff(const_coeff), .linear_coeff(linear_coeff),
        .quad_coeff(quad_coeff), .singular(singular), .saturated(saturated),
        .points_used(points_used)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        fit_t r;
        if (rst_n && done) begin
            r.c0 = const_coeff; r.c1 = linear_coeff; r.c2 = quad_coeff;
            r.sing = singular; r.sat = saturated; r.npts = points_used;
            sb.check_fit(r);
        end
    end

    task automatic send_point(input logic [11:0] x, input logic [11:0] y, input logic last,
                              input bit idle_ok);
        int gap;
        gap = idle_ok ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        x_value <= x;
        y_value <= y;
        last_point <= last;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        sb.note_point(x, y, last);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_set(input int npts, input bit narrow, input bit idle_ok);
        logic [11:0] base, x;
        base = $urandom_range(0, 4095);
        for (int i = 0; i < npts; i++) begin
            x = narrow ? 12'(base + $urandom_range(0, 3)) : 12'($urandom_range(0, 4095));
            send_point(x, 12'($urandom_range(0, 4095)), i == npts - 1, idle_ok);
        end
    endtask

    initial begin
        sb = new();
        sb.clear_sums();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_point(12'd0, 12'd0, 1'b0, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0, 1'b0);
        send_point(12'd2048, 12'd0, 1'b1, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b1, 1'b1);
        send_point(12'd5, 12'd1, 1'b0, 1'b1);
        send_point(12'd5, 12'd2, 1'b0, 1'b1);
        send_point(12'd7, 12'd4095, 1'b1, 1'b1);
        for (int i = 0; i < 17; i++)
            send_point(12'(i * 240), 12'(4095 - i * 200), i == 16, i[0]);

        while (sent < 1950) begin
            int kind;
            kind = $urandom_range(0, 19);
            if (kind == 0)
                send_set($urandom_range(1, 2), 1'b0, 1'b1);
            else if (kind == 1)
                send_set($urandom_range(17, 20), 1'b0, 1'b1);
            else
                send_set($urandom_range(3, 16), kind < 6, kind > 3);
        end
        start <= 1'b0;

        while (sb.pending_fits.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
